[hdl/dhc_pkg.sv]
// Types and constants shared by the DTLS header compressor modules.
// No dependencies; every other file of the block imports this package.
package dhc_pkg;

  localparam int unsigned HDR_LEN   = 13;
  localparam int unsigned STORE_LEN = HDR_LEN - 1;

  localparam logic [7:0] TYPE_APPDATA = 8'd23;
  localparam logic [7:0] VER_HI       = 8'hFE;
  localparam logic [7:0] VER_LO       = 8'hFD;
  localparam logic [7:0] EPOCH_HI     = 8'h00;
  localparam logic [7:0] EPOCH_LO     = 8'h01;

  // Status codes carried on every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  // Header bytes kept per rule.
  localparam logic [3:0] KEEP_STRICT  = 4'd8;
  localparam logic [3:0] KEEP_RELAXED = 4'd11;
  localparam logic [3:0] KEEP_NONE    = 4'd13;

  // Position of the final burst byte per rule (burst length minus one).
  localparam logic [3:0] LASTPOS_STRICT  = 4'd8;
  localparam logic [3:0] LASTPOS_RELAXED = 4'd11;
  localparam logic [3:0] LASTPOS_NONE    = 4'd13;

  // Configuration register indexes.
  localparam logic [1:0] REG_CODE_NONE    = 2'd0;
  localparam logic [1:0] REG_CODE_STRICT  = 2'd1;
  localparam logic [1:0] REG_CODE_RELAXED = 2'd2;
  localparam logic [1:0] REG_MAX_LEN      = 2'd3;

  typedef enum logic [1:0] {
    RULE_NONE    = 2'd0,
    RULE_STRICT  = 2'd1,
    RULE_RELAXED = 2'd2
  } rule_e;

  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_HDR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] record_len;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  status;
    logic [16:0] compressed_len;
  } out_t;

  typedef struct packed {
    logic [7:0]  code_none;
    logic [7:0]  code_strict;
    logic [7:0]  code_relaxed;
    logic [16:0] max_len;
  } cfg_t;

  // One queue entry: a pass-through byte, an error, or a whole header burst.
  typedef struct packed {
    cmd_kind_e              kind;
    rule_e                  rule;
    logic [7:0]             data;    // payload byte or rule byte
    logic [HDR_LEN-1:0][7:0] hdr;
    logic                   last;
    logic [1:0]             status;
    logic [16:0]            clen;
  } cmd_t;

endpackage

[hdl/dhc_front.sv]
// Front end: accepts record bytes, tracks position and length, holds the
// header and classifies it. Pushes one command per result-causing beat.
// Depends on dhc_pkg.
module dhc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dhc_pkg::in_t  in_data_i,
  input  dhc_pkg::cfg_t cfg_i,
  input  logic          q_full_i,
  output logic          push_o,
  output dhc_pkg::cmd_t cmd_o
);
  import dhc_pkg::*;

  logic [15:0] idx_q, idx_d;
  logic [15:0] len_q, len_d;
  logic        drop_q, drop_d;
  logic [16:0] total_q, total_d;
  logic [7:0]  hdr_q [STORE_LEN];

  logic        accept;
  logic [15:0] len_eff;
  logic        drop_cur;
  logic        ver_ok, strict_ok;
  logic [3:0]  keep;
  logic [16:0] need;
  logic [16:0] idx_nxt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classification of the held header (byte 12 is the current beat).
  assign ver_ok    = (hdr_q[1] == VER_HI) && (hdr_q[2] == VER_LO);
  assign strict_ok = ver_ok && (hdr_q[0] == TYPE_APPDATA) &&
                     (hdr_q[3] == EPOCH_HI) && (hdr_q[4] == EPOCH_LO);
  assign keep      = strict_ok ? KEEP_STRICT : (ver_ok ? KEEP_RELAXED : KEEP_NONE);
  assign need      = {1'b0, len_eff} + {13'd0, keep} - 17'(STORE_LEN);
  assign idx_nxt   = {1'b0, idx_q} + 17'd1;

  always_comb begin
    len_d   = len_q;
    drop_d  = drop_q;
    total_d = total_q;
    idx_d   = idx_q;
    push_o  = 1'b0;
    cmd_o   = '0;

    // Length latch on the first byte; zero counts as one.
    if (idx_q == 16'd0) begin
      len_eff  = (in_data_i.record_len == 16'd0) ? 16'd1 : in_data_i.record_len;
      drop_cur = (len_eff < 16'(HDR_LEN));
    end else begin
      len_eff  = len_q;
      drop_cur = drop_q;
    end

    for (int i = 0; i < STORE_LEN; i++) begin
      cmd_o.hdr[i] = hdr_q[i];
    end
    cmd_o.hdr[HDR_LEN-1] = in_data_i.data_byte;

    if (accept) begin
      if (idx_q == 16'd0) begin
        len_d   = len_eff;
        total_d = '0;
      end
      drop_d = drop_cur;

      if (idx_q == 16'd0 && drop_cur) begin
        // Short record: single error result.
        push_o      = 1'b1;
        cmd_o.kind  = CMD_ERR;
        cmd_o.last  = 1'b1;
        cmd_o.status = ST_SHORT;
      end else if (!drop_cur && idx_q == 16'(STORE_LEN)) begin
        push_o = 1'b1;
        if (need > cfg_i.max_len) begin
          drop_d       = 1'b1;
          cmd_o.kind   = CMD_ERR;
          cmd_o.last   = 1'b1;
          cmd_o.status = ST_LIMIT;
        end else begin
          total_d      = need;
          cmd_o.kind   = CMD_HDR;
          cmd_o.rule   = strict_ok ? RULE_STRICT : (ver_ok ? RULE_RELAXED : RULE_NONE);
          cmd_o.data   = strict_ok ? cfg_i.code_strict :
                         (ver_ok ? cfg_i.code_relaxed : cfg_i.code_none);
          cmd_o.last   = (len_eff == 16'(HDR_LEN));
          cmd_o.status = ST_OK;
          cmd_o.clen   = need;
        end
      end else if (!drop_cur && idx_q >= 16'(HDR_LEN)) begin
        // Payload byte passes through.
        push_o       = 1'b1;
        cmd_o.kind   = CMD_PASS;
        cmd_o.data   = in_data_i.data_byte;
        cmd_o.last   = (idx_nxt == {1'b0, len_eff});
        cmd_o.status = ST_OK;
        cmd_o.clen   = cmd_o.last ? total_q : 17'd0;
      end

      // Record end resets position.
      if (idx_nxt >= {1'b0, len_eff}) begin
        idx_d  = '0;
        drop_d = 1'b0;
      end else begin
        idx_d = idx_nxt[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      len_q   <= '0;
      drop_q  <= 1'b0;
      total_q <= '0;
    end else begin
      idx_q   <= idx_d;
      len_q   <= len_d;
      drop_q  <= drop_d;
      total_q <= total_d;
    end
  end

  // Header store, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && idx_q < 16'(STORE_LEN)) begin
      hdr_q[idx_q[3:0]] <= in_data_i.data_byte;
    end
  end

endmodule

[hdl/dhc_queue.sv]
// Short command queue between front and back end.
// Depends on dhc_pkg for the entry type.
module dhc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dhc_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output dhc_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import dhc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer wrap at the depth, not at a power of two.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (do_pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

[hdl/dhc_back.sv]
// Back end: expands queue commands into result beats through an output
// register. Header bursts step a position counter. Depends on dhc_pkg.
module dhc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  dhc_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dhc_pkg::out_t out_data_o
);
  import dhc_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic       vld_q;
  out_t       out_q, out_d;
  logic       adv, final_beat;
  logic [3:0] lastpos, hsel;
  logic [7:0] hbyte;

  assign adv         = !vld_q || !out_stall_i;
  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  // Burst length and header byte index per rule.
  always_comb begin
    case (cmd_i.rule)
      RULE_STRICT: begin
        lastpos = LASTPOS_STRICT;
        hsel    = pos_q + 4'd4;
      end
      RULE_RELAXED: begin
        lastpos = LASTPOS_RELAXED;
        hsel    = (pos_q == 4'd1) ? 4'd0 : pos_q + 4'd1;
      end
      default: begin
        lastpos = LASTPOS_NONE;
        hsel    = pos_q - 4'd1;
      end
    endcase
    hbyte = (hsel < 4'(HDR_LEN)) ? cmd_i.hdr[hsel] : 8'd0;
  end

  assign final_beat = (cmd_i.kind != CMD_HDR) || (pos_q == lastpos);
  assign pop_o      = q_valid_i && adv && final_beat;

  // Result beat from the queue head.
  always_comb begin
    out_d = '0;
    pos_d = pos_q;
    case (cmd_i.kind)
      CMD_HDR: begin
        out_d.out_byte       = (pos_q == 4'd0) ? cmd_i.data : hbyte;
        out_d.last           = cmd_i.last && final_beat;
        out_d.status         = ST_OK;
        out_d.compressed_len = out_d.last ? cmd_i.clen : 17'd0;
      end
      CMD_ERR: begin
        out_d.last   = 1'b1;
        out_d.status = cmd_i.status;
      end
      default: begin
        out_d.out_byte       = cmd_i.data;
        out_d.last           = cmd_i.last;
        out_d.status         = ST_OK;
        out_d.compressed_len = cmd_i.clen;
      end
    endcase
    if (q_valid_i && adv) pos_d = final_beat ? 4'd0 : pos_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (adv) vld_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

endmodule

[hdl/dtls_header_compressor.sv]
// DTLS record header compressor. Path to the first result: command queue, then
// output register. Throughput: one byte per cycle through the payload unless
// the output stalls or the queue is full; a header burst gives 9, 12 or 14
// results from the single output register, QUEUE_DEPTH commands absorb it.
// Reset (rst_ni, async, active low) clears position, queue and output valid and
// returns the configuration registers to their defaults.
module dtls_header_compressor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dhc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dhc_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import dhc_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_valid, pop;
  logic wr_en;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_none    <= 8'd0;
      cfg_q.code_strict  <= 8'd1;
      cfg_q.code_relaxed <= 8'd2;
      cfg_q.max_len      <= 17'h10000;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CODE_NONE:    cfg_q.code_none    <= pwdata[7:0];
        REG_CODE_STRICT:  cfg_q.code_strict  <= pwdata[7:0];
        REG_CODE_RELAXED: cfg_q.code_relaxed <= pwdata[7:0];
        REG_MAX_LEN:      cfg_q.max_len      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CODE_NONE:    prdata = {24'd0, cfg_q.code_none};
      REG_CODE_STRICT:  prdata = {24'd0, cfg_q.code_strict};
      REG_CODE_RELAXED: prdata = {24'd0, cfg_q.code_relaxed};
      REG_MAX_LEN:      prdata = {15'd0, cfg_q.max_len};
      default:          prdata = '0;
    endcase
  end

  dhc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dhc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  dhc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/dhc_checker.sv]
// Port-level checks on the compressor output stream, bound to the top level.
// Depends on dhc_pkg.
module dhc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dhc_pkg::out_t out_data_o
);
  import dhc_pkg::*;

  // Error results always close the record.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last)
    else $error("error result without last");

  // Error results carry zero byte and zero length.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.out_byte == 8'd0 && out_data_o.compressed_len == 17'd0)
    else $error("error result with nonzero payload");

  // Length shows only on the final beat of a record.
  a_len_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.compressed_len == 17'd0)
    else $error("compressed length before last beat");

  // Status code is one of the defined values.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == ST_OK || out_data_o.status == ST_SHORT ||
                    out_data_o.status == ST_LIMIT)
    else $error("undefined status code");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind dtls_header_compressor dhc_checker u_dhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
